>>> rtl/core/rbrt_pkg.sv
// ----------------------------------------------------------------------------
// rbrt_pkg
// Shared constants and types for the buffer registration table.
// ----------------------------------------------------------------------------
package rbrt_pkg;

    localparam int ENTRIES  = 16;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int EXT_W    = 9;

    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 104;

    localparam logic [1:0] CMD_REG_REGULAR = 2'd0;
    localparam logic [1:0] CMD_REG_STREAM  = 2'd1;
    localparam logic [1:0] CMD_UNREGISTER  = 2'd2;
    localparam logic [1:0] CMD_READ        = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    localparam logic [2:0] FLAG_VALID  = 3'b001;
    localparam logic [2:0] FLAG_STREAM = 3'b010;
    localparam logic [2:0] FLAG_GENPUT = 3'b100;

    typedef struct packed {
        logic load;
        logic search;
        logic commit;
    } t_dp_ctrl;

endpackage

>>> rtl/core/rdma_buffer_registration_table.sv
// ----------------------------------------------------------------------------
// rdma_buffer_registration_table
// Table of registered RDMA buffers: register, unregister by magic, read slot.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one command per beat: s_axis_tuser is the command
//   (register regular, register streaming, unregister, read), s_axis_tdata
//   the start address, length, magic word and slot index.
//   Master stream returns exactly one result beat per command: m_axis_tuser
//   is the status (ok, table full, not found), m_axis_tdata the slot and the
//   entry fields.
//   Each command passes load, search and commit: the result beat becomes
//   valid when commit writes the result register, and a new command is
//   taken only after the previous one has committed. The search compares
//   all slot magic words and valid flags in one registered step; the
//   commit step updates the table and the result register.
//   The next command is taken while a result still waits. If the receiver
//   stalls, the following command holds in commit until the result register
//   is taken, so s_axis_tready stays low meanwhile.
//   Reset clears every slot to zero, drops m_axis_tvalid and sets s_axis_tready.
// ----------------------------------------------------------------------------
module rdma_buffer_registration_table (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [1:0] cmd
    input  logic [1:0]   s_axis_tuser,
    // [31:0] base_addr, [62:32] length, [94:63] magic, [98:95] slot_index
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [1:0] status
    output logic [1:0]   m_axis_tuser,
    // [3:0] slot, [35:4] entry_start, [67:36] entry_end, [99:68] entry_magic,
    // [102:100] entry_flags
    output logic [103:0] m_axis_tdata
);

    rbrt_pkg::t_dp_ctrl dp_ctrl;

    logic [3:0]  slot;
    logic [31:0] entry_start;
    logic [31:0] entry_end;
    logic [31:0] entry_magic;
    logic [2:0]  entry_flags;

    rbrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_dp_ctrl   (dp_ctrl)
    );

    rbrt_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dp_ctrl     (dp_ctrl),
        .i_cmd         (s_axis_tuser),
        .i_base_addr   (s_axis_tdata[31:0]),
        .i_length      (s_axis_tdata[62:32]),
        .i_magic       (s_axis_tdata[94:63]),
        .i_slot_index  (s_axis_tdata[98:95]),
        .o_status      (m_axis_tuser),
        .o_slot        (slot),
        .o_entry_start (entry_start),
        .o_entry_end   (entry_end),
        .o_entry_magic (entry_magic),
        .o_entry_flags (entry_flags)
    );

    assign m_axis_tdata = {1'b0, entry_flags, entry_magic, entry_end, entry_start, slot};

endmodule

>>> rtl/core/rbrt_ctrl.sv
// ----------------------------------------------------------------------------
// rbrt_ctrl
// Command sequencer: load, search, commit, and output beat handshake.
// ----------------------------------------------------------------------------
module rbrt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rbrt_pkg::t_dp_ctrl o_dp_ctrl
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state          = r_state;
        n_out_valid      = r_out_valid && !i_out_ready;
        o_dp_ctrl        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_dp_ctrl.load = 1'b1;
                    n_state        = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_dp_ctrl.search = 1'b1;
                n_state          = S_COMMIT;
            end
            S_COMMIT: begin
                if (out_free) begin
                    o_dp_ctrl.commit = 1'b1;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> rtl/core/rbrt_datapath.sv
// ----------------------------------------------------------------------------
// rbrt_datapath
// Slot table, free/match search vectors, slot update and result register.
// ----------------------------------------------------------------------------
module rbrt_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rbrt_pkg::t_dp_ctrl  i_dp_ctrl,
    input  logic [1:0]          i_cmd,
    input  logic [31:0]         i_base_addr,
    input  logic [30:0]         i_length,
    input  logic [31:0]         i_magic,
    input  logic [3:0]          i_slot_index,
    output logic [1:0]          o_status,
    output logic [3:0]          o_slot,
    output logic [31:0]         o_entry_start,
    output logic [31:0]         o_entry_end,
    output logic [31:0]         o_entry_magic,
    output logic [2:0]          o_entry_flags
);

    logic [31:0] r_tab_start [rbrt_pkg::ENTRIES];
    logic [31:0] r_tab_end   [rbrt_pkg::ENTRIES];
    logic [31:0] r_tab_magic [rbrt_pkg::ENTRIES];
    logic [2:0]  r_tab_flags [rbrt_pkg::ENTRIES];

    logic [1:0]  r_cmd;
    logic [31:0] r_start;
    logic [30:0] r_len;
    logic [31:0] r_magic;
    logic [3:0]  r_idx;
    logic [31:0] r_end;

    logic [rbrt_pkg::ENTRIES-1:0] r_free;
    logic [rbrt_pkg::ENTRIES-1:0] r_match;

    logic [1:0]  r_status, n_status;
    logic [3:0]  r_slot, n_slot;
    logic [31:0] r_o_start, n_o_start;
    logic [31:0] r_o_end, n_o_end;
    logic [31:0] r_o_magic, n_o_magic;
    logic [2:0]  r_o_flags, n_o_flags;

    logic [rbrt_pkg::IDX_W-1:0] free_idx, match_idx, rd_idx;
    logic [rbrt_pkg::EXT_W-1:0] idx_ext, free_ext, match_ext;
    logic                       free_any, match_any, rd_in_range;
    logic [2:0]                 new_flags;
    logic                       do_write, do_clear;

    always_comb begin
        free_idx  = '0;
        match_idx = '0;
        for (int i = rbrt_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                free_idx = rbrt_pkg::IDX_W'(i);
            end
            if (r_match[i]) begin
                match_idx = rbrt_pkg::IDX_W'(i);
            end
        end
    end

    assign free_any    = |r_free;
    assign match_any   = |r_match;
    assign idx_ext     = rbrt_pkg::EXT_W'(r_idx);
    assign free_ext    = rbrt_pkg::EXT_W'(free_idx);
    assign match_ext   = rbrt_pkg::EXT_W'(match_idx);
    assign rd_idx      = idx_ext[rbrt_pkg::IDX_W-1:0];
    assign rd_in_range = idx_ext < rbrt_pkg::EXT_W'(rbrt_pkg::ENTRIES);
    assign new_flags   = rbrt_pkg::FLAG_VALID | rbrt_pkg::FLAG_GENPUT
                       | ((r_cmd == rbrt_pkg::CMD_REG_STREAM) ? rbrt_pkg::FLAG_STREAM : 3'b000);

    always_comb begin
        n_status  = rbrt_pkg::ST_OK;
        n_slot    = '0;
        n_o_start = '0;
        n_o_end   = '0;
        n_o_magic = '0;
        n_o_flags = '0;
        do_write  = 1'b0;
        do_clear  = 1'b0;
        case (r_cmd) inside
            rbrt_pkg::CMD_REG_REGULAR, rbrt_pkg::CMD_REG_STREAM: begin
                if (free_any) begin
                    do_write  = 1'b1;
                    n_slot    = free_ext[3:0];
                    n_o_start = r_start;
                    n_o_end   = r_end;
                    n_o_magic = r_magic;
                    n_o_flags = new_flags;
                end else begin
                    n_status = rbrt_pkg::ST_FULL;
                end
            end
            rbrt_pkg::CMD_UNREGISTER: begin
                if (match_any) begin
                    do_clear = 1'b1;
                    n_slot   = match_ext[3:0];
                end else begin
                    n_status = rbrt_pkg::ST_NOTFOUND;
                end
            end
            default: begin
                n_slot = r_idx;
                if (rd_in_range) begin
                    n_o_start = r_tab_start[rd_idx];
                    n_o_end   = r_tab_end[rd_idx];
                    n_o_magic = r_tab_magic[rd_idx];
                    n_o_flags = r_tab_flags[rd_idx];
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rbrt_pkg::ENTRIES; i++) begin
                r_tab_start[i] <= '0;
                r_tab_end[i]   <= '0;
                r_tab_magic[i] <= '0;
                r_tab_flags[i] <= '0;
            end
        end else if (i_dp_ctrl.commit) begin
            if (do_write) begin
                r_tab_start[free_idx] <= r_start;
                r_tab_end[free_idx]   <= r_end;
                r_tab_magic[free_idx] <= r_magic;
                r_tab_flags[free_idx] <= new_flags;
            end
            if (do_clear) begin
                r_tab_start[match_idx] <= '0;
                r_tab_end[match_idx]   <= '0;
                r_tab_magic[match_idx] <= '0;
                r_tab_flags[match_idx] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_ctrl.load) begin
            r_cmd   <= i_cmd;
            r_start <= i_base_addr;
            r_len   <= i_length;
            r_magic <= i_magic;
            r_idx   <= i_slot_index;
        end
        if (i_dp_ctrl.search) begin
            r_end <= r_start + 32'(r_len);
            for (int i = 0; i < rbrt_pkg::ENTRIES; i++) begin
                r_free[i]  <= !r_tab_flags[i][0];
                r_match[i] <= (r_tab_magic[i] == r_magic);
            end
        end
        if (i_dp_ctrl.commit) begin
            r_status  <= n_status;
            r_slot    <= n_slot;
            r_o_start <= n_o_start;
            r_o_end   <= n_o_end;
            r_o_magic <= n_o_magic;
            r_o_flags <= n_o_flags;
        end
    end

    assign o_status      = r_status;
    assign o_slot        = r_slot;
    assign o_entry_start = r_o_start;
    assign o_entry_end   = r_o_end;
    assign o_entry_magic = r_o_magic;
    assign o_entry_flags = r_o_flags;

endmodule
